/* sv/assert_macros.svh */
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/post_span_pkg.sv */
package post_span_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W       = 12;
   localparam int ARG_W       = 5;
   localparam int SPAN_W      = 13;
   localparam int KIND_W      = 2;
   localparam int MODE_W      = 2;
   localparam int SUM_W       = 10;
   // signed pointer must reach minus the largest group size
   localparam int PTR_W       = ((FILL_W > ARG_W + 1) ? FILL_W : ARG_W + 1) + 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [MODE_W-1:0] MODE_LEAF    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BLANK   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_KEYWORD = 2'd2;
   localparam logic [MODE_W-1:0] MODE_COMMAND = 2'd3;

   localparam logic [KIND_W-1:0] KIND_CONSUMED = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PUSHED   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_IGNORED  = 2'd2;

   localparam logic [SPAN_W-1:0] SENTINEL_START = {SPAN_W{1'b1}};

   typedef enum logic [1:0] {
      OP_LEAF,
      OP_BLANK,
      OP_KEYWORD,
      OP_COMMAND
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [IDX_W-1:0]   index;
      logic [ARG_W-1:0]   arg_count;
      logic [ARG_W-1:0]   keyword_count;
   } token_type;

   typedef struct packed {
      logic [SPAN_W-1:0]  start;
      logic [SPAN_W-1:0]  count;
      logic [ARG_W-1:0]   marker;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM_RD,
      ST_SUM_ACC,
      ST_PLAN,
      ST_EMIT_RD,
      ST_EMIT_OUT,
      ST_PUSH
   } state_type;

endpackage

/* sv/postfix_operand_span_tracker_unit.sv */
// channel   | direction | fields
// req_      | in        | index, mode, arg_count, keyword_count
// rsp_      | out       | result_kind, span_start, span_count, overflow, last
//
// a leaf or blank goes from idle to push; a keyword marker reads and emits its n bound values, then pushes
// a command sums the markers of its k keyword groups, plans, emits its p plain entries and k groups, then pushes
// each entry is read through the single read port of the span stack before it is emitted
// reset is synchronous, active high; it empties the stack and the token queue
// a two-entry token queue lets requests land while the sequencer waits on rsp_stall
module postfix_operand_span_tracker_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [post_span_pkg::IDX_W-1:0]      req_index,
   input  logic [post_span_pkg::MODE_W-1:0]     req_mode,
   input  logic [post_span_pkg::ARG_W-1:0]      req_arg_count,
   input  logic [post_span_pkg::ARG_W-1:0]      req_keyword_count,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [post_span_pkg::KIND_W-1:0]     rsp_result_kind,
   output logic signed [post_span_pkg::SPAN_W-1:0] rsp_span_start,
   output logic [post_span_pkg::SPAN_W-1:0]     rsp_span_count,
   output logic                                 rsp_overflow,
   output logic                                 rsp_last
);

   // decoded tokens between the front queue and the sequencer
   logic                      tok_valid;
   logic                      tok_take;
   post_span_pkg::token_type  tok_data;

   // front: accepts and classifies requests into the queue
   post_span_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_index         (req_index),
      .req_mode          (req_mode),
      .req_arg_count     (req_arg_count),
      .req_keyword_count (req_keyword_count),
      .tok_valid         (tok_valid),
      .tok_data          (tok_data),
      .tok_take          (tok_take)
   );

   // back: pops, reports and pushes spans on the stack memory
   post_span_back u_back (
      .clock           (clock),
      .reset           (reset),
      .tok_valid       (tok_valid),
      .tok_data        (tok_data),
      .tok_take        (tok_take),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_span_start  (rsp_span_start),
      .rsp_span_count  (rsp_span_count),
      .rsp_overflow    (rsp_overflow),
      .rsp_last        (rsp_last)
   );

endmodule

/* sv/post_span_ram.sv */
module post_span_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/post_span_front.sv */
module post_span_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [post_span_pkg::IDX_W-1:0]      req_index,
   input  logic [post_span_pkg::MODE_W-1:0]     req_mode,
   input  logic [post_span_pkg::ARG_W-1:0]      req_arg_count,
   input  logic [post_span_pkg::ARG_W-1:0]      req_keyword_count,
   output logic                                 tok_valid,
   output post_span_pkg::token_type             tok_data,
   input  logic                                 tok_take
);

   post_span_pkg::token_type           q_ff [post_span_pkg::QUEUE_DEPTH];
   logic [post_span_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [post_span_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [post_span_pkg::QCNT_W-1:0]   cnt_ff, cnt_in;
   post_span_pkg::token_type           tok_class;
   logic                               push, pop;

   // decode the token kind
   always_comb begin
      tok_class.index         = req_index;
      tok_class.arg_count     = req_arg_count;
      tok_class.keyword_count = req_keyword_count;
      case (req_mode)
         post_span_pkg::MODE_LEAF:    tok_class.op = post_span_pkg::OP_LEAF;
         post_span_pkg::MODE_BLANK:   tok_class.op = post_span_pkg::OP_BLANK;
         post_span_pkg::MODE_KEYWORD: tok_class.op = post_span_pkg::OP_KEYWORD;
         default:                     tok_class.op = post_span_pkg::OP_COMMAND;
      endcase
   end

   assign req_stall = (cnt_ff == post_span_pkg::QCNT_W'(post_span_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign pop       = tok_take && tok_valid;
   assign tok_valid = (cnt_ff != '0);
   assign tok_data  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= tok_class;
      end
   end

endmodule

/* sv/post_span_back.sv */
module post_span_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 tok_valid,
   input  post_span_pkg::token_type             tok_data,
   output logic                                 tok_take,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [post_span_pkg::KIND_W-1:0]     rsp_result_kind,
   output logic signed [post_span_pkg::SPAN_W-1:0] rsp_span_start,
   output logic [post_span_pkg::SPAN_W-1:0]     rsp_span_count,
   output logic                                 rsp_overflow,
   output logic                                 rsp_last
);

   localparam int PW = post_span_pkg::PTR_W;
   localparam int FW = post_span_pkg::FILL_W;
   localparam int SW = post_span_pkg::SPAN_W;
   localparam int AW = post_span_pkg::ARG_W;

   post_span_pkg::state_type  state_ff, state_in;
   post_span_pkg::token_type  tok_ff, tok_in;
   logic [FW-1:0]             fill_ff, fill_in;
   logic [FW-1:0]             lo_ff, lo_in;
   logic signed [PW-1:0]      kbase_ff, kbase_in;
   logic signed [PW-1:0]      addr_ff, addr_in;
   logic [AW-1:0]             cnt_ff, cnt_in;
   logic [post_span_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic                      seg_key_ff, seg_key_in;
   logic signed [SW-1:0]      start_ff, start_in;
   logic                      any_ff, any_in;

   logic                      out_valid_ff, out_valid_in;
   logic [post_span_pkg::KIND_W-1:0] out_kind_ff, out_kind_in;
   logic signed [SW-1:0]      out_start_ff, out_start_in;
   logic [SW-1:0]             out_count_ff, out_count_in;
   logic                      out_ovf_ff, out_ovf_in;
   logic                      out_last_ff, out_last_in;

   logic                      wr_en;
   post_span_pkg::entry_type  wr_entry, rd_entry;
   logic [post_span_pkg::ADDR_W-1:0] wr_addr;

   logic                      out_free;
   logic [AW-1:0]             first_n;
   logic signed [PW-1:0]      kbase_calc;
   logic [FW-1:0]             kbase_clamp;
   logic [AW-1:0]             plain;
   logic signed [PW-1:0]      pbase;
   logic                      entry_real;
   logic signed [SW-1:0]      ent_start;
   logic [SW-1:0]             ent_count;
   logic signed [SW-1:0]      push_start;
   logic [SW-1:0]             push_count;
   logic                      push_ovf;
   logic                      cnt_one;

   post_span_ram #(
      .WIDTH($bits(post_span_pkg::entry_type)),
      .DEPTH(post_span_pkg::STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (addr_ff[post_span_pkg::ADDR_W-1:0]),
      .rd_data (rd_entry)
   );

   assign out_free = !out_valid_ff || !rsp_stall;
   assign cnt_one  = (cnt_ff == AW'(1));

   // group base: keyword groups of a command, bound values of a marker
   assign first_n    = (tok_data.op == post_span_pkg::OP_COMMAND) ?
                       tok_data.keyword_count : tok_data.arg_count;
   assign kbase_calc = PW'(fill_ff) - PW'(first_n);
   assign kbase_clamp = kbase_ff[PW-1] ? '0 : kbase_ff[FW-1:0];
   assign plain = ({5'b0, tok_ff.arg_count} > sum_ff) ?
                  tok_ff.arg_count - sum_ff[AW-1:0] : '0;
   assign pbase = PW'(kbase_clamp) - PW'(plain);

   // negative addresses are pops of an empty stack
   assign entry_real = !addr_ff[PW-1];
   assign ent_start  = entry_real ? rd_entry.start : post_span_pkg::SENTINEL_START;
   assign ent_count  = entry_real ? rd_entry.count : '0;

   assign push_start = any_ff ? start_ff : SW'(tok_ff.index);
   assign push_count = SW'({1'b0, tok_ff.index}) - push_start + SW'(1);
   assign push_ovf   = (lo_ff >= FW'(post_span_pkg::STACK_DEPTH));

   assign wr_addr         = lo_ff[post_span_pkg::ADDR_W-1:0];
   assign wr_entry.start  = push_start;
   assign wr_entry.count  = push_count;
   assign wr_entry.marker = (tok_ff.op == post_span_pkg::OP_KEYWORD) ?
                            tok_ff.arg_count : '0;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         post_span_pkg::ST_IDLE: begin
            if (tok_valid) begin
               case (tok_data.op)
                  post_span_pkg::OP_COMMAND:
                     state_in = (tok_data.keyword_count != '0) ?
                                post_span_pkg::ST_SUM_RD : post_span_pkg::ST_PLAN;
                  post_span_pkg::OP_KEYWORD:
                     state_in = (tok_data.arg_count != '0) ?
                                post_span_pkg::ST_EMIT_RD : post_span_pkg::ST_PUSH;
                  default: state_in = post_span_pkg::ST_PUSH;
               endcase
            end
         end
         post_span_pkg::ST_SUM_RD:  state_in = post_span_pkg::ST_SUM_ACC;
         post_span_pkg::ST_SUM_ACC:
            state_in = cnt_one ? post_span_pkg::ST_PLAN : post_span_pkg::ST_SUM_RD;
         post_span_pkg::ST_PLAN: begin
            if (plain != '0 || tok_ff.keyword_count != '0) begin
               state_in = post_span_pkg::ST_EMIT_RD;
            end else begin
               state_in = post_span_pkg::ST_PUSH;
            end
         end
         post_span_pkg::ST_EMIT_RD: state_in = post_span_pkg::ST_EMIT_OUT;
         post_span_pkg::ST_EMIT_OUT: begin
            if (out_free) begin
               if (!cnt_one || (!seg_key_ff && tok_ff.keyword_count != '0)) begin
                  state_in = post_span_pkg::ST_EMIT_RD;
               end else begin
                  state_in = post_span_pkg::ST_PUSH;
               end
            end
         end
         post_span_pkg::ST_PUSH: begin
            if (out_free) begin
               state_in = post_span_pkg::ST_IDLE;
            end
         end
         default: state_in = post_span_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      tok_take     = 1'b0;
      tok_in       = tok_ff;
      fill_in      = fill_ff;
      lo_in        = lo_ff;
      kbase_in     = kbase_ff;
      addr_in      = addr_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      seg_key_in   = seg_key_ff;
      start_in     = start_ff;
      any_in       = any_ff;
      wr_en        = 1'b0;
      out_valid_in = out_valid_ff && rsp_stall;
      out_kind_in  = out_kind_ff;
      out_start_in = out_start_ff;
      out_count_in = out_count_ff;
      out_ovf_in   = out_ovf_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         post_span_pkg::ST_IDLE: begin
            if (tok_valid) begin
               tok_take   = 1'b1;
               tok_in     = tok_data;
               kbase_in   = kbase_calc;
               addr_in    = kbase_calc;
               cnt_in     = first_n;
               sum_in     = '0;
               any_in     = 1'b0;
               seg_key_in = 1'b1;
               if (tok_data.op == post_span_pkg::OP_KEYWORD) begin
                  lo_in = kbase_calc[PW-1] ? '0 : kbase_calc[FW-1:0];
               end else begin
                  lo_in = fill_ff;
               end
            end
         end
         post_span_pkg::ST_SUM_ACC: begin
            if (entry_real) begin
               sum_in = sum_ff + post_span_pkg::SUM_W'(rd_entry.marker);
            end
            addr_in = addr_ff + PW'(1);
            cnt_in  = cnt_ff - AW'(1);
         end
         post_span_pkg::ST_PLAN: begin
            lo_in = pbase[PW-1] ? '0 : pbase[FW-1:0];
            if (plain != '0) begin
               seg_key_in = 1'b0;
               addr_in    = pbase;
               cnt_in     = plain;
            end else begin
               seg_key_in = 1'b1;
               addr_in    = kbase_ff;
               cnt_in     = tok_ff.keyword_count;
            end
         end
         post_span_pkg::ST_EMIT_OUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = post_span_pkg::KIND_CONSUMED;
               out_start_in = ent_start;
               out_count_in = ent_count;
               out_ovf_in   = 1'b0;
               out_last_in  = 1'b0;
               any_in       = 1'b1;
               // a marker keeps its oldest start, a command the smallest
               if (!any_ff || (tok_ff.op == post_span_pkg::OP_COMMAND &&
                               ent_start < start_ff)) begin
                  start_in = ent_start;
               end
               if (cnt_one && !seg_key_ff) begin
                  seg_key_in = 1'b1;
                  addr_in    = kbase_ff;
                  cnt_in     = tok_ff.keyword_count;
               end else begin
                  addr_in = addr_ff + PW'(1);
                  cnt_in  = cnt_ff - AW'(1);
               end
            end
         end
         post_span_pkg::ST_PUSH: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_last_in  = 1'b1;
               if (tok_ff.op == post_span_pkg::OP_BLANK) begin
                  out_kind_in  = post_span_pkg::KIND_IGNORED;
                  out_start_in = '0;
                  out_count_in = '0;
                  out_ovf_in   = 1'b0;
               end else begin
                  out_kind_in  = post_span_pkg::KIND_PUSHED;
                  out_start_in = push_start;
                  out_count_in = push_count;
                  out_ovf_in   = push_ovf;
                  wr_en        = !push_ovf;
                  fill_in      = push_ovf ? lo_ff : lo_ff + FW'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= post_span_pkg::ST_IDLE;
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         out_valid_ff <= out_valid_in;
      end
      tok_ff       <= tok_in;
      lo_ff        <= lo_in;
      kbase_ff     <= kbase_in;
      addr_ff      <= addr_in;
      cnt_ff       <= cnt_in;
      sum_ff       <= sum_in;
      seg_key_ff   <= seg_key_in;
      start_ff     <= start_in;
      any_ff       <= any_in;
      out_kind_ff  <= out_kind_in;
      out_start_ff <= out_start_in;
      out_count_ff <= out_count_in;
      out_ovf_ff   <= out_ovf_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_result_kind = out_kind_ff;
   assign rsp_span_start  = out_start_ff;
   assign rsp_span_count  = out_count_ff;
   assign rsp_overflow    = out_ovf_ff;
   assign rsp_last        = out_last_ff;

endmodule

/* sv/post_span_checker.sv */
`include "assert_macros.svh"

module post_span_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic [post_span_pkg::KIND_W-1:0]     rsp_result_kind,
   input  logic [post_span_pkg::SPAN_W-1:0]     rsp_span_count,
   input  logic                                 rsp_overflow,
   input  logic                                 rsp_last
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp dropped")
   `ASSERT_IMPLY(a_ovf_push, clock, reset, rsp_valid && rsp_overflow,
      rsp_result_kind == post_span_pkg::KIND_PUSHED, "overflow off a push")
   `ASSERT_IMPLY(a_ignored, clock, reset,
      rsp_valid && rsp_result_kind == post_span_pkg::KIND_IGNORED,
      rsp_last && rsp_span_count == '0, "bad ignored result")
   `ASSERT_IMPLY(a_last_kind, clock, reset, rsp_valid,
      rsp_last == (rsp_result_kind != post_span_pkg::KIND_CONSUMED), "last misplaced")

endmodule

bind postfix_operand_span_tracker_unit post_span_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_result_kind (rsp_result_kind),
   .rsp_span_count  (rsp_span_count),
   .rsp_overflow    (rsp_overflow),
   .rsp_last        (rsp_last)
);
